[src/snfm_pkg.sv]
// Shared types, codes and the sector table for the sectored NOR flash model.
// No dependencies; imported by snfm_lanes and sectored_nor_flash_model_unit.
package snfm_pkg;

  // Geometry
  localparam int FLASH_BYTES = 2097152;
  localparam int SECTORS     = 24;
  localparam int BYTE_AW     = $clog2(FLASH_BYTES);       // 21
  localparam int WORD_AW     = $clog2(FLASH_BYTES / 4);   // 19
  localparam logic [7:0] SECTOR_LIMIT = 8'(SECTORS);

  // Operation kinds
  localparam logic [1:0] KIND_READ    = 2'd0;
  localparam logic [1:0] KIND_PROG_B  = 2'd1;
  localparam logic [1:0] KIND_PROG_W  = 2'd2;
  localparam logic [1:0] KIND_ERASE   = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_SECTOR = 3'd1;
  localparam logic [2:0] ST_RANGE      = 3'd2;
  localparam logic [2:0] ST_ALIGN      = 3'd3;
  localparam logic [2:0] ST_SETBITS    = 3'd4;

  // Write request into the four byte lanes
  typedef struct packed {
    logic [3:0]         en;
    logic [WORD_AW-1:0] addr;
    logic [31:0]        data;
  } wr_req_t;

  // Start byte address of a sector; index SECTORS gives the array end
  function automatic logic [BYTE_AW:0] sec_base(input logic [4:0] idx);
    logic [BYTE_AW:0] b;
    case (idx)
      5'd0:  b = 22'h000000;
      5'd1:  b = 22'h004000;
      5'd2:  b = 22'h008000;
      5'd3:  b = 22'h00C000;
      5'd4:  b = 22'h010000;
      5'd5:  b = 22'h020000;
      5'd6:  b = 22'h040000;
      5'd7:  b = 22'h060000;
      5'd8:  b = 22'h080000;
      5'd9:  b = 22'h0A0000;
      5'd10: b = 22'h0C0000;
      5'd11: b = 22'h0E0000;
      5'd12: b = 22'h100000;
      5'd13: b = 22'h104000;
      5'd14: b = 22'h108000;
      5'd15: b = 22'h10C000;
      5'd16: b = 22'h110000;
      5'd17: b = 22'h120000;
      5'd18: b = 22'h140000;
      5'd19: b = 22'h160000;
      5'd20: b = 22'h180000;
      5'd21: b = 22'h1A0000;
      5'd22: b = 22'h1C0000;
      5'd23: b = 22'h1E0000;
      5'd24: b = 22'h200000;
      default: b = '0;
    endcase
    return b;
  endfunction

  // Sector size in bytes
  function automatic logic [17:0] sec_size(input logic [4:0] idx);
    logic [17:0] s;
    case (idx)
      5'd0, 5'd1, 5'd2, 5'd3,
      5'd12, 5'd13, 5'd14, 5'd15: s = 18'h04000;
      5'd4, 5'd16:                s = 18'h10000;
      5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11,
      5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22, 5'd23: s = 18'h20000;
      default:                    s = '0;
    endcase
    return s;
  endfunction

  // Last word index of a sector
  function automatic logic [WORD_AW-1:0] sec_last_word(input logic [4:0] idx);
    logic [BYTE_AW:0] nb;
    nb = sec_base(idx + 5'd1);
    return WORD_AW'((nb >> 2) - 22'd1);
  endfunction

endpackage

[src/sectored_nor_flash_model_unit.sv]
// Top level of the sectored NOR flash model: command port, sequencer, checks.
// Depends on snfm_pkg and snfm_lanes.
//
// A command is taken when start is high and busy is low; its result shows on
// status and read_data for one cycle with done high, and the receiver cannot
// stall it. Reads and programs hold busy through a check state and then one
// read-modify-write of the byte-lane memories in the merge state; done is
// registered from the merge state, and the next command may already be taken
// while it is high. An erase walks its sector one 32-bit row per cycle
// through the shared address adder, for sectors of 16, 64 or 128 KiB.
// Commands that fail a check, and zero-length reads, finish in the check
// state. After reset the array is filled with 0xFF one row per cycle, so
// busy stays high until the whole array is filled, before the first command is taken.
module sectored_nor_flash_model_unit
  import snfm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [7:0]  sector,
  input  logic [16:0] offset,
  input  logic [2:0]  length,
  input  logic [31:0] data,
  output logic        done,
  output logic [2:0]  status,
  output logic [31:0] read_data
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_MERGE = 3'd3;
  localparam logic [2:0] S_ERASE = 3'd4;

  logic [2:0]         state, state_next;
  logic [1:0]         op_kind;
  logic [7:0]         op_sector;
  logic [16:0]        op_offset;
  logic [2:0]         op_length;
  logic [31:0]        op_data;
  logic [BYTE_AW-1:0] baddr;
  logic [WORD_AW-1:0] ptr;
  logic [WORD_AW-1:0] last;

  logic                    accept;
  logic [BYTE_AW:0]        base_cur;
  logic [BYTE_AW-1:0]      add_a, add_b, add_sum;
  logic                    sec_ok;
  logic [4:0]              idx;
  logic [2:0]              acc_size;
  logic [17:0]             acc_end;
  logic                    in_range;
  logic [2:0]              chk_status;
  logic [WORD_AW-1:0]      row0, row1;
  logic [3:0][WORD_AW-1:0] rd_addr;
  logic [31:0]             rd_data;
  wr_req_t                 wr;
  logic [31:0]             rd_bytes;
  logic [1:0]              lane;
  logic [7:0]              cur_byte;
  logic                    prog_ok;
  logic                    finish;
  logic [2:0]              fin_status;
  logic [31:0]             fin_data;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign idx      = op_sector[4:0];
  assign base_cur = sec_base(idx);

  // Shared adder: base + offset while checking, row pointer + 1 while sweeping
  always_comb begin
    if (state == S_CHECK) begin
      add_a = base_cur[BYTE_AW-1:0];
      add_b = BYTE_AW'(op_offset);
    end else begin
      add_a = BYTE_AW'(ptr);
      add_b = BYTE_AW'(1);
    end
  end
  assign add_sum = add_a + add_b;

  // Sector and range checks, in the order alignment, sector, range
  always_comb begin
    sec_ok = (op_sector < SECTOR_LIMIT);
    case (op_kind)
      KIND_READ:   acc_size = op_length;
      KIND_PROG_B: acc_size = 3'd1;
      default:     acc_size = 3'd4;
    endcase
    acc_end  = 18'(op_offset) + 18'(acc_size);
    in_range = (acc_end <= sec_size(idx));
    case (op_kind)
      KIND_READ: begin
        if (op_length > 3'd4) chk_status = sec_ok ? ST_RANGE : ST_BAD_SECTOR;
        else if (!sec_ok)     chk_status = ST_BAD_SECTOR;
        else if (!in_range)   chk_status = ST_RANGE;
        else                  chk_status = ST_OK;
      end
      KIND_PROG_B: begin
        if (!sec_ok)        chk_status = ST_BAD_SECTOR;
        else if (!in_range) chk_status = ST_RANGE;
        else                chk_status = ST_OK;
      end
      KIND_PROG_W: begin
        if (op_offset[1:0] != 2'b00) chk_status = ST_ALIGN;
        else if (!sec_ok)            chk_status = ST_BAD_SECTOR;
        else if (!in_range)          chk_status = ST_RANGE;
        else                         chk_status = ST_OK;
      end
      default: chk_status = sec_ok ? ST_OK : ST_BAD_SECTOR;
    endcase
  end

  // Lane read rows: lanes below the start lane come from the next row
  assign row0 = add_sum[BYTE_AW-1:2];
  assign row1 = row0 + WORD_AW'(1);
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      rd_addr[l] = (2'(l) >= add_sum[1:0]) ? row0 : row1;
    end
  end

  // Byte gather for reads and the set-bits check for programs
  always_comb begin
    rd_bytes = '0;
    lane     = '0;
    for (int i = 0; i < 4; i++) begin
      lane = baddr[1:0] + 2'(i);  // lane index wraps at four
      if (3'(i) < op_length) begin
        rd_bytes[8*i +: 8] = rd_data[8*lane +: 8];
      end
    end
    cur_byte = rd_data[8*baddr[1:0] +: 8];
    if (op_kind == KIND_PROG_B) prog_ok = ((cur_byte & op_data[7:0]) == op_data[7:0]);
    else                        prog_ok = ((rd_data & op_data) == op_data);
  end

  // Write port: sweep fill, or program after a passing check
  always_comb begin
    wr.en   = 4'b0000;
    wr.addr = ptr;
    wr.data = 32'hFFFF_FFFF;
    case (state)
      S_CLEAR, S_ERASE: wr.en = 4'b1111;
      S_MERGE: begin
        wr.addr = baddr[BYTE_AW-1:2];
        if (op_kind == KIND_PROG_W && prog_ok) begin
          wr.en   = 4'b1111;
          wr.data = op_data;
        end else if (op_kind == KIND_PROG_B && prog_ok) begin
          wr.en   = 4'b0001 << baddr[1:0];
          wr.data = {4{op_data[7:0]}};
        end
      end
      default: wr.en = 4'b0000;
    endcase
  end

  snfm_lanes u_lanes (
    .clk     (clk),
    .rd_addr (rd_addr),
    .wr      (wr),
    .rd_data (rd_data)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    finish     = 1'b0;
    fin_status = ST_OK;
    fin_data   = '0;
    case (state)
      S_CLEAR: begin
        if (ptr == '1) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (chk_status != ST_OK || (op_kind == KIND_READ && op_length == 3'd0)) begin
          finish     = 1'b1;
          fin_status = chk_status;
          state_next = S_IDLE;
        end else if (op_kind == KIND_ERASE) begin
          state_next = S_ERASE;
        end else begin
          state_next = S_MERGE;
        end
      end
      S_MERGE: begin
        finish     = 1'b1;
        state_next = S_IDLE;
        if (op_kind == KIND_READ)  fin_data   = rd_bytes;
        else if (!prog_ok)         fin_status = ST_SETBITS;
      end
      S_ERASE: begin
        if (ptr == last) begin
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ptr   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
      if (state == S_CLEAR || state == S_ERASE) begin
        ptr <= add_sum[WORD_AW-1:0];
      end else if (state == S_CHECK) begin
        ptr <= base_cur[BYTE_AW-1:2];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind   <= kind;
      op_sector <= sector;
      op_offset <= offset;
      op_length <= length;
      op_data   <= data;
    end
    if (state == S_CHECK) begin
      baddr <= add_sum;
      last  <= sec_last_word(idx);
    end
    if (finish) begin
      status    <= fin_status;
      read_data <= fin_data;
    end
  end

  // Checks
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_CHECK || $past(state) == S_MERGE ||
              $past(state) == S_ERASE))
    else $error("done without a command in flight");

  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_CHECK))
    else $error("accepted command did not enter check");

  a_fail_no_data: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (read_data == 32'd0))
    else $error("failed command returned read data");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (wr.en != 4'b0000) |-> (state != S_IDLE && state != S_CHECK))
    else $error("array written outside a write state");

  a_erase_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_ERASE) |-> (ptr <= last))
    else $error("erase pointer ran past sector end");

endmodule

[src/snfm_lanes.sv]
// Flash array as four byte-lane memories, one 32-bit word row per address.
// Each lane reads its own row every cycle (registered); writes share a row.
// Depends on snfm_pkg.
module snfm_lanes
  import snfm_pkg::*;
(
  input  logic                    clk,
  input  logic [3:0][WORD_AW-1:0] rd_addr,
  input  wr_req_t                 wr,
  output logic [31:0]             rd_data
);

  localparam int Depth = FLASH_BYTES / 4;

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [7:0] mem [Depth];

    // one write and one registered read per cycle
    always_ff @(posedge clk) begin
      if (wr.en[l]) begin
        mem[wr.addr] <= wr.data[8*l +: 8];
      end
      rd_data[8*l +: 8] <= mem[rd_addr[l]];
    end
  end

endmodule
